// ----- hw/rtl/prt_pkg.sv -----
// Shared types, codes and defaults of the pending reply tracker.
`timescale 1ns / 1ps
package prt_pkg;

   localparam int PRT_CONNECTIONS  = 8;
   localparam int PRT_POOL_ENTRIES = 16;

   localparam int CONN_W    = 3;
   localparam int SEQ_W     = 32;
   localparam int SEQ_LOW_W = 16;
   localparam int OPC_W     = 8;

   localparam logic [1:0] MODE_REQUEST = 2'd0;
   localparam logic [1:0] MODE_LOOKUP  = 2'd1;
   localparam logic [1:0] MODE_REPEAT  = 2'd2;
   localparam logic [1:0] MODE_FLUSH   = 2'd3;

   typedef struct packed {
      logic [1:0]           mode;
      logic [CONN_W-1:0]    connection;
      logic                 expects_reply;
      logic [SEQ_LOW_W-1:0] reply_sequence;
      logic [OPC_W-1:0]     request_type;
      logic [OPC_W-1:0]     request_minor;
   } prt_req_type;

   typedef struct packed {
      logic             found;
      logic [OPC_W-1:0] matched_request;
      logic [OPC_W-1:0] matched_minor;
      logic [SEQ_W-1:0] matched_full_sequence;
      logic [SEQ_W-1:0] assigned_sequence;
      logic             overflow;
   } prt_rsp_type;

   // One pool entry; also the layout of the last-match register.
   typedef struct packed {
      logic [CONN_W-1:0] conn;
      logic [SEQ_W-1:0]  seq;
      logic [OPC_W-1:0]  req;
      logic [OPC_W-1:0]  minor;
   } prt_entry_type;

   // Tag that every cell compares against its entry.
   typedef struct packed {
      logic [CONN_W-1:0]    conn;
      logic [SEQ_LOW_W-1:0] seq;
      logic                 use_seq;
   } prt_probe_type;

   // Operation broadcast to all cells.
   typedef struct packed {
      logic          append;
      logic          remove;
      prt_entry_type append_entry;
   } prt_cell_ctl_type;

   // Handed from cell to cell: any older hit, and the oldest hit's entry.
   typedef struct packed {
      logic          kill;
      prt_entry_type sel;
   } prt_link_type;

   typedef struct packed {
      logic          any_hit;
      logic          full;
      prt_entry_type hit_entry;
   } prt_pool_status_type;

endpackage

// ----- hw/rtl/pending_reply_tracker.sv -----
// Top level: outstanding request tracker with per-connection sequence counters.
`timescale 1ns / 1ps
//
//  channel  ports                          handshake
//  -------  -----------------------------  ---------------------------------
//  command  start, busy, req_payload       beat taken when start && !busy
//  result   rsp_strobe, rsp_payload        one beat per command, one cycle
//
//  For a request, lookup or repeat the accept edge registers the command and
//  every cell's tag compare, the next edge applies it to the pool and counters.
//  A flush repeats compare and apply until the connection has no entry left,
//  as the pool drops one entry per compare/apply pass. The result shows the
//  cycle after the apply edge, when busy is already low. Reset is synchronous
//  and empties the pool and clears all counters. The receiver cannot stall.
//
module pending_reply_tracker #(
   parameter int CONNECTIONS  = prt_pkg::PRT_CONNECTIONS,
   parameter int POOL_ENTRIES = prt_pkg::PRT_POOL_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  prt_pkg::prt_req_type req_payload,
   output logic                 rsp_strobe,
   output prt_pkg::prt_rsp_type rsp_payload
);
   import prt_pkg::*;

   localparam int CIDX_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_APPLY = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;

   logic [1:0]          state_ff, state_in;
   prt_req_type         cmd_ff;
   logic [SEQ_W-1:0]    counter_ff [CONNECTIONS];
   prt_entry_type       last_match_ff;
   logic                rsp_strobe_ff;
   prt_rsp_type         rsp_payload_ff;

   logic [6:0]          conn_wide;
   logic [CIDX_W-1:0]   conn_idx;
   logic                conn_ok;
   logic [SEQ_W-1:0]    seq_next;
   logic                counter_we;
   logic                last_match_we;
   logic                done;
   prt_rsp_type         rsp_in;
   prt_cell_ctl_type    ctl;
   prt_probe_type       probe;
   prt_pool_status_type pool_status;

   assign conn_wide = {4'd0, cmd_ff.connection};
   assign conn_idx  = conn_wide[CIDX_W-1:0];
   assign conn_ok   = ({29'd0, cmd_ff.connection} < 32'(CONNECTIONS));
   assign seq_next  = counter_ff[conn_idx] + 32'd1;

   // Compare against the incoming beat while idle, else against the held one.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         probe.conn    = req_payload.connection;
         probe.seq     = req_payload.reply_sequence;
         probe.use_seq = (req_payload.mode != MODE_FLUSH);
      end else begin
         probe.conn    = cmd_ff.connection;
         probe.seq     = cmd_ff.reply_sequence;
         probe.use_seq = (cmd_ff.mode != MODE_FLUSH);
      end
   end

   // Apply step: decide pool operation, counter update and result.
   always_comb begin
      ctl           = '0;
      rsp_in        = '0;
      counter_we    = 1'b0;
      last_match_we = 1'b0;
      done          = 1'b1;
      if ((state_ff == ST_APPLY) && conn_ok) begin
         case (cmd_ff.mode)
            MODE_REQUEST: begin
               counter_we               = 1'b1;
               rsp_in.assigned_sequence = seq_next;
               ctl.append               = cmd_ff.expects_reply;
               ctl.append_entry.conn    = cmd_ff.connection;
               ctl.append_entry.seq     = seq_next;
               ctl.append_entry.req     = cmd_ff.request_type;
               ctl.append_entry.minor   = cmd_ff.request_minor;
               rsp_in.overflow          = cmd_ff.expects_reply && pool_status.full;
            end
            MODE_LOOKUP: begin
               ctl.remove    = 1'b1;
               last_match_we = pool_status.any_hit;
               if (pool_status.any_hit) begin
                  rsp_in.found                 = 1'b1;
                  rsp_in.matched_request       = pool_status.hit_entry.req;
                  rsp_in.matched_minor         = pool_status.hit_entry.minor;
                  rsp_in.matched_full_sequence = pool_status.hit_entry.seq;
               end
            end
            MODE_REPEAT: begin
               ctl.append       = 1'b1;
               ctl.append_entry = last_match_ff;
               rsp_in.overflow  = pool_status.full;
            end
            MODE_FLUSH: begin
               // drop the oldest entry of the connection, then probe again
               ctl.remove = pool_status.any_hit;
               done       = !pool_status.any_hit;
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = done ? ST_IDLE : ST_PROBE;
         end
         ST_PROBE: begin
            state_in = ST_APPLY;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   prt_pool #(
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_pool (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .probe  (probe),
      .status (pool_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         last_match_ff <= '0;
         for (int i = 0; i < CONNECTIONS; i++) begin
            counter_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_APPLY) && done;
         if (last_match_we) begin
            last_match_ff <= pool_status.hit_entry;
         end
         if (counter_we) begin
            counter_ff[conn_idx] <= seq_next;
         end
      end
   end

   // hold the command and the result payload
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && start) begin
         cmd_ff <= req_payload;
      end
      if ((state_ff == ST_APPLY) && done) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE))
      else $error("result beat while a command is still in work");

   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.found) |->
         (rsp_payload.assigned_sequence == '0) && !rsp_payload.overflow)
      else $error("lookup result carries request fields");

   a_accept_apply: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_APPLY))
      else $error("accepted beat not applied");

endmodule

// ----- hw/rtl/prt_cell.sv -----
// One slot of the age-ordered pool: entry storage, tag compare and shift.
`timescale 1ns / 1ps
module prt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  prt_pkg::prt_cell_ctl_type ctl,
   input  prt_pkg::prt_probe_type   probe,
   input  logic                     left_valid,
   input  logic                     right_valid,
   input  prt_pkg::prt_entry_type   right_entry,
   input  prt_pkg::prt_link_type    link_in,
   output prt_pkg::prt_link_type    link_out,
   output logic                     valid,
   output prt_pkg::prt_entry_type   entry
);
   import prt_pkg::*;

   logic          valid_ff, valid_in;
   logic          hit_ff, hit_in;
   prt_entry_type entry_ff, entry_in;
   logic          load_entry;
   logic          first_hit;

   assign hit_in = valid_ff && (entry_ff.conn == probe.conn) &&
                   (!probe.use_seq || (entry_ff.seq[SEQ_LOW_W-1:0] == probe.seq));

   assign first_hit     = hit_ff && !link_in.kill;
   assign link_out.kill = link_in.kill || hit_ff;
   assign link_out.sel  = link_in.sel | (first_hit ? entry_ff : '0);

   always_comb begin
      valid_in   = valid_ff;
      entry_in   = entry_ff;
      load_entry = 1'b0;
      if (ctl.remove && (link_in.kill || hit_ff)) begin
         // close the gap: take the younger neighbor's slot
         valid_in   = right_valid;
         entry_in   = right_entry;
         load_entry = 1'b1;
      end else if (ctl.append && !valid_ff && left_valid) begin
         valid_in   = 1'b1;
         entry_in   = ctl.append_entry;
         load_entry = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_entry) begin
         entry_ff <= entry_in;
      end
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

// ----- hw/rtl/prt_pool.sv -----
// Chain of pool cells kept compacted oldest first, with full and hit status.
`timescale 1ns / 1ps
module prt_pool #(
   parameter int POOL_ENTRIES = prt_pkg::PRT_POOL_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  prt_pkg::prt_cell_ctl_type    ctl,
   input  prt_pkg::prt_probe_type      probe,
   output prt_pkg::prt_pool_status_type status
);
   import prt_pkg::*;

   logic [POOL_ENTRIES-1:0] valid_vec;
   prt_entry_type           entry_vec [POOL_ENTRIES];
   prt_link_type            link_vec  [POOL_ENTRIES+1];

   assign link_vec[0] = '0;

   for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
      logic          left_valid;
      logic          right_valid;
      prt_entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_valid = valid_vec[i-1];
      end

      if (i == POOL_ENTRIES - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_entry = '0;
      end else begin : g_next
         assign right_valid = valid_vec[i+1];
         assign right_entry = entry_vec[i+1];
      end

      prt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .probe       (probe),
         .left_valid  (left_valid),
         .right_valid (right_valid),
         .right_entry (right_entry),
         .link_in     (link_vec[i]),
         .link_out    (link_vec[i+1]),
         .valid       (valid_vec[i]),
         .entry       (entry_vec[i])
      );
   end

   assign status.any_hit   = link_vec[POOL_ENTRIES].kill;
   assign status.hit_entry = link_vec[POOL_ENTRIES].sel;
   assign status.full      = valid_vec[POOL_ENTRIES-1];

   // valid slots always form one run starting at slot 0
   a_compact: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + {{POOL_ENTRIES{1'b0}}, 1'b1}))
      else $error("pool has a gap between valid slots");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ctl.append && ctl.remove))
      else $error("append and remove in the same cycle");

endmodule
